// ===== src/ldw_pkg.sv =====
// Package for the longest distinct window block: sizes, request types and the
// controller/datapath command and status structs. No dependencies.
package ldw_pkg;

	// Ring history depth and stored value width.
	localparam int HISTORY_DEPTH = 256;
	localparam int VALUE_WIDTH   = 32;

	// Ring pointer width and the width of a count that can hold HISTORY_DEPTH itself.
	localparam int PTR_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

	// Width of the reported length fields.
	localparam int LEN_W = 9;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic                   first;
	} ldw_in_t;

	typedef struct packed {
		logic [LEN_W-1:0] window_length;
		logic [LEN_W-1:0] best_length;
		logic             overflow;
	} ldw_out_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} ldw_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture a new request and start a search
		logic issue;  // read the next older ring entry
		logic update; // commit the window result and write the ring
	} ldw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic can_issue; // entries of the window remain to be read
		logic pending;   // a read is in flight toward the comparator
		logic hit;       // the entry in the compare stage equals the value
		logic out_free;  // the output register can take a new result
	} ldw_sts_t;

endpackage

// ===== src/ldw_ctrl.sv =====
// Controller state machine for the longest distinct window block.
// Depends on ldw_pkg for the state, command and status types.
module ldw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ldw_pkg::ldw_sts_t sts,
	output ldw_pkg::ldw_cmd_t cmd
);
	import ldw_pkg::*;

	ldw_state_t state_q;
	ldw_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// Keep one read in flight per cycle until a hit or the window ends.
				cmd.issue = sts.can_issue && !sts.hit;
				if (sts.hit) begin
					state_d = ST_UPDATE;
				end else if (!sts.can_issue && !sts.pending) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (sts.out_free) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/ldw_datapath.sv =====
// Datapath for the longest distinct window block: ring history memory, search
// counter, compare stage, window state and output register. Depends on ldw_pkg.
module ldw_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ldw_pkg::ldw_in_t  in_data,
	input  ldw_pkg::ldw_cmd_t cmd,
	output ldw_pkg::ldw_sts_t sts,
	output logic              out_valid,
	input  logic              out_stall,
	output ldw_pkg::ldw_out_t out_data
);
	import ldw_pkg::*;

	// Ring history memory.
	logic [VALUE_WIDTH-1:0] history_q [HISTORY_DEPTH];
	logic [VALUE_WIDTH-1:0] rd_data_s1;
	logic                   rd_valid_s1;
	logic [CNT_W-1:0]       dist_s1;

	// Request and window state.
	logic [VALUE_WIDTH-1:0] value_q;
	logic [PTR_W-1:0]       wptr_q;
	logic [CNT_W-1:0]       len_q;
	logic [CNT_W-1:0]       best_q;
	logic                   ovf_q;
	logic [CNT_W-1:0]       dist_q;
	logic                   match_q;
	logic [CNT_W-1:0]       match_dist_q;
	logic                   out_valid_q;
	ldw_out_t               out_q;

	logic [PTR_W-1:0]       rd_addr;
	logic                   hit;
	logic [CNT_W-1:0]       new_len;
	logic                   new_ovf;
	logic [CNT_W-1:0]       new_best;

	// Distance d reads slot wptr - d; the low bits of d suffice for a ring.
	assign rd_addr = wptr_q - dist_q[PTR_W-1:0];
	assign hit     = rd_valid_s1 && (rd_data_s1 == value_q);

	// Memory read and write ports.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_data_s1 <= history_q[rd_addr];
			dist_s1    <= dist_q;
		end
		if (cmd.update) begin
			history_q[wptr_q] <= value_q;
		end
	end

	// Read valid flag for the compare stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.issue;
		end
	end

	// Request capture and search bookkeeping.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= in_data.value;
			dist_q  <= CNT_W'(1);
		end else if (cmd.issue) begin
			dist_q  <= dist_q + CNT_W'(1);
		end
		if (cmd.load) begin
			match_q <= 1'b0;
		end else if (hit) begin
			match_q      <= 1'b1;
			match_dist_q <= dist_s1;
		end
	end

	// Window result: a match sets the length, otherwise grow or saturate.
	always_comb begin
		new_ovf = ovf_q;
		if (match_q) begin
			new_len = match_dist_q;
		end else if (len_q >= CNT_W'(HISTORY_DEPTH)) begin
			new_len = CNT_W'(HISTORY_DEPTH);
			new_ovf = 1'b1;
		end else begin
			new_len = len_q + CNT_W'(1);
		end
		new_best = (new_len > best_q) ? new_len : best_q;
	end

	// Window state; a first flag empties the window before the search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			len_q  <= '0;
			best_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.load && in_data.first) begin
			len_q  <= '0;
			best_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.update) begin
			len_q  <= new_len;
			best_q <= new_best;
			ovf_q  <= new_ovf;
			wptr_q <= wptr_q + PTR_W'(1);
		end
	end

	// Output register, freed when the receiver takes the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_q.window_length <= LEN_W'(new_len);
			out_q.best_length   <= LEN_W'(new_best);
			out_q.overflow      <= new_ovf;
		end
	end

	// Status toward the controller.
	assign sts.can_issue = (dist_q <= len_q);
	assign sts.pending   = rd_valid_s1;
	assign sts.hit       = hit;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== src/longest_distinct_window.sv =====
// Top level of the longest distinct window block: joins controller and datapath.
// Depends on ldw_pkg, ldw_ctrl and ldw_datapath.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  ldw_in_t  (value, first)
//   out      output     out_valid/out_stall ldw_out_t (window_length, best_length, overflow)
//
// With no match, a request searches the whole window of length L before it (at most
// 256); the backward search reads one ring entry per cycle through the single memory
// read port, and the search waits for the last compare to settle before the commit.
// A match at distance d ends the search early; an empty window is not read at all.
// Reset clears the window, the best length, the overflow flag and the ring pointer;
// the ring contents need no clearing. A new request is taken while a result waits
// in the output register; a stalled output holds only the final commit step.
module longest_distinct_window (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ldw_pkg::ldw_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ldw_pkg::ldw_out_t out_data
);
	import ldw_pkg::*;

	ldw_cmd_t cmd;
	ldw_sts_t sts;

	// Sequencing of search and commit.
	ldw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Ring memory, comparator and window state.
	ldw_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== verif/tb_longest_distinct_window.sv =====
`timescale 1ns / 1ps
// Testbench for longest_distinct_window: a directed table, then shaped random requests.
// It checks typed rows by table, others by its predictor. Depends on ldw_pkg and the RTL.
module tb_longest_distinct_window;
	import ldw_pkg::*;

	localparam int PHASE_REQUESTS = 267;
	localparam int HOLDOFF_CYCLES = 800;
	localparam int TAIL_CYCLES    = HISTORY_DEPTH + 16;
	localparam int CYCLE_LIMIT    = 2_000_000;

	typedef enum {PH_SENDER_IDLE, PH_RECEIVER_IDLE, PH_STEADY} phase_t;
	typedef enum {SEG_FEW_VALUES, SEG_DISTINCT, SEG_NOISE} segment_t;

	// One directed request; the expected result is used only where typed is set.
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic                   first;
		logic                   typed;
		logic [LEN_W-1:0]       window_length;
		logic [LEN_W-1:0]       best_length;
		logic                   overflow;
	} directed_row_t;

	directed_row_t directed_rows [22] = '{
		'{32'h0000_0000, 1'b1, 1'b1, 9'd1, 9'd1, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 9'd2, 9'd2, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 9'd1, 9'd2, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'h8000_0000, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'h7FFF_FFFF, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'h8000_0000, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'h0000_0000, 1'b1, 1'b1, 9'd1, 9'd1, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b1, 9'd1, 9'd1, 1'b0},
		'{32'hA5A5_A5A5, 1'b1, 1'b1, 9'd1, 9'd1, 1'b0},
		'{32'h5A5A_5A5A, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'h1234_5678, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'hDEAD_BEEF, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'hA5A5_A5A5, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 9'd1, 9'd1, 1'b0},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 9'd1, 9'd1, 1'b0},
		'{32'hFFFF_FFFE, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'h5555_5555, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'hAAAA_AAAA, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0},
		'{32'hFFFF_FFFE, 1'b0, 1'b0, 9'd0, 9'd0, 1'b0}
	};

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_stall;
	ldw_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	ldw_out_t out_data;

	int unsigned idle_pct       = 20;
	int unsigned stall_pct      = 63;
	bit          holdoff_start  = 1'b0;
	bit          holdoff_taken  = 1'b0;
	int unsigned holdoff_left   = 0;
	int unsigned requests_sent  = 0;
	int          mismatch_count = 0;
	ldw_out_t    pending_windows [$];
	ldw_out_t    expected_res;

	// Predictor state: ring of past values, write slot, window and best lengths.
	logic [VALUE_WIDTH-1:0] ring_model [HISTORY_DEPTH];
	logic [PTR_W-1:0]       ring_wr  = '0;
	logic [CNT_W-1:0]       run_len  = '0;
	logic [CNT_W-1:0]       best_len = '0;
	logic                   ovf_seen = 1'b0;

	longest_distinct_window u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #10 clk = ~clk;

	// Search the window newest to oldest, then grow, shrink or saturate it.
	task automatic predict_window(input ldw_in_t req, output ldw_out_t res);
		int               d;
		int               hit_dist;
		logic [PTR_W-1:0] slot;
		if (req.first) begin
			run_len  = '0;
			best_len = '0;
			ovf_seen = 1'b0;
		end
		hit_dist = 0;
		for (d = 1; d <= run_len && hit_dist == 0; d++) begin
			slot = ring_wr - PTR_W'(d);
			if (ring_model[slot] == req.value)
				hit_dist = d;
		end
		if (hit_dist != 0) begin
			run_len = CNT_W'(hit_dist);
		end else if (run_len >= HISTORY_DEPTH) begin
			run_len  = CNT_W'(HISTORY_DEPTH);
			ovf_seen = 1'b1;
		end else begin
			run_len = run_len + CNT_W'(1);
		end
		if (run_len > best_len)
			best_len = run_len;
		ring_model[ring_wr] = req.value;
		ring_wr = ring_wr + PTR_W'(1);
		res.window_length = LEN_W'(run_len);
		res.best_length   = LEN_W'(best_len);
		res.overflow      = ovf_seen;
	endtask

	// Offer one request, wait for it to be taken, and queue its expected result.
	task automatic send_request(input ldw_in_t req, input bit typed, input ldw_out_t typed_res);
		ldw_out_t predicted;
		while ($urandom_range(99, 0) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_window(req, predicted);
		pending_windows.insert(pending_windows.size(), typed ? typed_res : predicted);
		requests_sent++;
	endtask

	// A run of requests: a few repeated values, a distinct run, or pure noise.
	// Most few-value and distinct runs open with first set; some continue the previous sequence instead.
	task automatic run_segment(input segment_t kind, input int unsigned count);
		logic [VALUE_WIDTH-1:0] alphabet [16];
		logic [VALUE_WIDTH-1:0] base;
		logic [VALUE_WIDTH-1:0] step;
		int unsigned            alpha_n;
		int unsigned            i;
		ldw_in_t                req;
		alpha_n = $urandom_range(16, 1);
		foreach (alphabet[k]) begin
			case ($urandom_range(5, 0))
				0: alphabet[k] = '0;
				1: alphabet[k] = '1;
				default: alphabet[k] = $urandom;
			endcase
		end
		base = $urandom;
		step = $urandom | 1;
		for (i = 0; i < count; i++) begin
			if (i == 0)
				req.first = (count > HISTORY_DEPTH) || ($urandom_range(7, 0) != 0);
			else
				req.first = (count <= HISTORY_DEPTH) && ($urandom_range(59, 0) == 0);
			case (kind)
				SEG_FEW_VALUES: begin
					req.value = alphabet[$urandom_range(alpha_n - 1, 0)];
				end
				SEG_DISTINCT: begin
					// Long runs stay distinct until the window has saturated.
					if (i > 8 && (count > HISTORY_DEPTH ? i > HISTORY_DEPTH : 1'b1)
							&& $urandom_range(4, 0) == 0)
						req.value = base + step * (i - $urandom_range(8, 1));
					else
						req.value = base + step * i;
				end
				default: begin
					req.value = $urandom;
					req.first = ($urandom_range(3, 0) == 0);
				end
			endcase
			send_request(req, 1'b0, '0);
		end
	endtask

	// Receiver: random stall, plus one long hold-off counted here.
	always @(posedge clk) begin
		if (holdoff_start && !holdoff_taken) begin
			holdoff_taken <= 1'b1;
			holdoff_left  <= HOLDOFF_CYCLES;
			out_stall     <= 1'b1;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
			out_stall    <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	task automatic report_field(input string name, input int unsigned want, input int unsigned got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		mismatch_count++;
	endtask

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_windows.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, got %0d/%0d/%0d",
					$time, out_data.window_length, out_data.best_length, out_data.overflow);
				mismatch_count++;
			end else begin
				expected_res = pending_windows.pop_front();
				if (out_data.window_length != expected_res.window_length)
					report_field("window_length", 32'(expected_res.window_length),
						32'(out_data.window_length));
				if (out_data.best_length != expected_res.best_length)
					report_field("best_length", 32'(expected_res.best_length),
						32'(out_data.best_length));
				if (out_data.overflow != expected_res.overflow)
					report_field("overflow", 32'(expected_res.overflow),
						32'(out_data.overflow));
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("longest_distinct_window test failed");
		$finish;
	end

	initial begin
		int          p;
		phase_t      phase;
		int unsigned phase_start;
		int unsigned roll;
		ldw_in_t     req;
		ldw_out_t    typed_res;

		foreach (ring_model[k])
			ring_model[k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: extremes, restarts, repeats at several distances.
		foreach (directed_rows[r]) begin
			req.value                 = directed_rows[r].value;
			req.first                 = directed_rows[r].first;
			typed_res.window_length   = directed_rows[r].window_length;
			typed_res.best_length     = directed_rows[r].best_length;
			typed_res.overflow        = directed_rows[r].overflow;
			send_request(req, directed_rows[r].typed, typed_res);
		end

		// Random part in three idling phases.
		for (p = 0; p < 3; p++) begin
			phase = phase_t'(p);
			case (phase)
				PH_SENDER_IDLE: begin
					idle_pct  = 20;
					stall_pct = 63;
				end
				PH_RECEIVER_IDLE: begin
					idle_pct  = 63;
					stall_pct = 20;
					// The sender pauses until every outstanding result has come.
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_windows.size() != 0)
						@(posedge clk);
				end
				default: begin
					idle_pct      = 0;
					stall_pct     = 0;
					holdoff_start = 1'b1;
				end
			endcase
			phase_start = requests_sent;
			// A distinct run long enough to saturate the window and set overflow.
			if (phase != PH_RECEIVER_IDLE)
				run_segment(SEG_DISTINCT, HISTORY_DEPTH + $urandom_range(18, 2));
			while (requests_sent - phase_start < PHASE_REQUESTS) begin
				roll = $urandom_range(99, 0);
				if (roll < 65)
					run_segment(SEG_FEW_VALUES, $urandom_range(40, 4));
				else if (roll < 85)
					run_segment(SEG_DISTINCT, $urandom_range(60, 10));
				else
					run_segment(SEG_NOISE, $urandom_range(16, 2));
			end
		end

		// Drain, then give the block time to show any stray result.
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_windows.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("longest_distinct_window test passed");
		else
			$display("longest_distinct_window test failed");
		$finish;
	end

endmodule
